### sv/bts_pkg.sv
// Shared types, constants and code conversions for the bit-plane text word search.
package bts_pkg;

  localparam int CODE_W       = 5;
  localparam int PACK_COLUMNS = 12;
  localparam int MASK_W       = 64;
  localparam int MPOS_W       = 6;
  localparam int CHAR_W       = 8;
  localparam int WORD_W       = CODE_W * PACK_COLUMNS;

  localparam logic [CODE_W-1:0] DOT_CODE   = CODE_W'(26);
  localparam logic [CODE_W-1:0] BLANK_CODE = CODE_W'(31);

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] ASCII_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_READ   = 2'd3
  } bts_func_t;

  typedef struct packed {
    bts_func_t         func;
    logic [CHAR_W-1:0] char_in;
    logic [WORD_W-1:0] word_codes;
    logic [MPOS_W-1:0] position;
  } bts_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] match_mask;
    logic              any_match;
    logic [MPOS_W-1:0] first_match_pos;
    logic [MPOS_W-1:0] last_match_pos;
    logic [CHAR_W-1:0] char_out;
  } bts_out_t;

  typedef struct packed {
    logic              valid;
    logic              find;
    logic              word_ok;
    logic [CHAR_W-1:0] char_out;
  } bts_ctrl_t;

  function automatic logic [CODE_W-1:0] ascii_to_code(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
      d = ch - ASCII_UPPER_A;
      return d[CODE_W-1:0];
    end
    if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
      d = ch - ASCII_LOWER_A;
      return d[CODE_W-1:0];
    end
    if (ch == ASCII_DOT) return DOT_CODE;
    return BLANK_CODE;
  endfunction

  function automatic logic [CHAR_W-1:0] code_to_ascii(input logic [CODE_W-1:0] code);
    if (code < DOT_CODE) return ASCII_UPPER_A + {{(CHAR_W-CODE_W){1'b0}}, code};
    if (code == DOT_CODE) return ASCII_DOT;
    return ASCII_SPACE;
  endfunction

endpackage

### sv/bts_lane.sv
// One word column lane: compares its column code against every text position.
module bts_lane #(
  parameter int TEXT_POSITIONS = 64,
  parameter int COLUMN         = 0
) (
  input  logic [TEXT_POSITIONS-1:0][bts_pkg::CODE_W-1:0] text_codes,
  input  logic [bts_pkg::CODE_W-1:0]                     col_code,
  input  logic                                           col_active,
  output logic [TEXT_POSITIONS-1:0]                      hits
);
  import bts_pkg::*;

  for (genvar p = 0; p < TEXT_POSITIONS; p++) begin : g_pos
    if (p + COLUMN < TEXT_POSITIONS) begin : g_in
      assign hits[p] = !col_active || (text_codes[p+COLUMN] == col_code);
    end else begin : g_out
      assign hits[p] = !col_active;
    end
  end

endmodule

### sv/bts_merge.sv
// Merging stage: ANDs the lane hits into the start mask and encodes first and last match.
module bts_merge #(
  parameter int TEXT_POSITIONS = 64,
  parameter int WORD_COLUMNS   = 12
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [WORD_COLUMNS-1:0][TEXT_POSITIONS-1:0] lane_hits,
  input  bts_pkg::bts_ctrl_t                          ctrl,
  output logic                                        out_valid,
  output bts_pkg::bts_out_t                           out_item
);
  import bts_pkg::*;

  logic [MASK_W-1:0] mask_nxt;
  logic [MASK_W-1:0] mask_r;
  bts_ctrl_t         ctrl_r;
  bts_out_t          out_nxt;
  bts_out_t          out_item_r;
  logic              out_valid_r;

  always_comb begin
    logic [TEXT_POSITIONS-1:0] all_hit;
    all_hit = '1;
    for (int i = 0; i < WORD_COLUMNS; i++) begin
      all_hit = all_hit & lane_hits[i];
    end
    mask_nxt = '0;
    if (ctrl.find && ctrl.word_ok) begin
      for (int p = 0; p < TEXT_POSITIONS; p++) begin
        mask_nxt[MASK_W-1-p] = all_hit[p];
      end
    end
  end

  always_comb begin
    out_nxt                 = '0;
    out_nxt.match_mask      = mask_r;
    out_nxt.any_match       = |mask_r;
    out_nxt.char_out        = ctrl_r.char_out;
    for (int p = TEXT_POSITIONS - 1; p >= 0; p--) begin
      if (mask_r[MASK_W-1-p]) out_nxt.first_match_pos = MPOS_W'(p);
    end
    for (int p = 0; p < TEXT_POSITIONS; p++) begin
      if (mask_r[MASK_W-1-p]) out_nxt.last_match_pos = MPOS_W'(p);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r      <= ctrl;
      out_valid_r <= ctrl_r.valid;
    end
    mask_r     <= mask_nxt;
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_any_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.any_match == (out_item.match_mask != '0)))
    else $error("any_match disagrees with match_mask");

  a_first_le_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.any_match |-> out_item.first_match_pos <= out_item.last_match_pos)
    else $error("first match after last match");

  a_char_excludes_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.char_out != '0) |-> (out_item.match_mask == '0))
    else $error("read-back item carries a match mask");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.valid |=> ##1 out_valid)
    else $error("accepted item produced no result");

endmodule

### sv/bitplane_text_word_search.sv
// Top level of the case-insensitive text page with parallel word search.
// One item is accepted every cycle: busy is held low, so start is taken at every rising edge
// at which it is high. Each item gives exactly one result, strobed on out_valid for one cycle
// after both registers: the column lanes and their AND merge feed the mask register, and the
// first/last position encoders feed the output register. The receiver cannot stall, so every
// result must be taken in its strobe cycle. Items act on the page in acceptance order; an
// append or clear is visible to the next item. Clear empties the whole page.
module bitplane_text_word_search #(
  parameter int TEXT_POSITIONS = 64,
  parameter int WORD_COLUMNS   = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bts_pkg::bts_in_t  in_item,
  output logic              out_valid,
  output bts_pkg::bts_out_t out_item
);
  import bts_pkg::*;

  localparam int POS_W  = $clog2(TEXT_POSITIONS);
  localparam int FILL_W = $clog2(TEXT_POSITIONS + 1);

  logic [TEXT_POSITIONS-1:0][CODE_W-1:0] text_r;
  logic [TEXT_POSITIONS-1:0][CODE_W-1:0] text_nxt;
  logic [FILL_W-1:0]                     fill_r;
  logic [FILL_W-1:0]                     fill_nxt;
  logic                                  accept;
  logic [WORD_COLUMNS-1:0][CODE_W-1:0]   col_code;
  logic [WORD_COLUMNS-1:0]               col_active;
  logic [WORD_COLUMNS-1:0][TEXT_POSITIONS-1:0] lane_hits;
  bts_ctrl_t                             ctrl;
  logic [CODE_W-1:0]                     read_code;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    logic prev;
    prev = 1'b1;
    for (int i = 0; i < WORD_COLUMNS; i++) begin
      col_code[i]   = in_item.word_codes[WORD_W-1-CODE_W*i -: CODE_W];
      col_active[i] = prev && (col_code[i] <= DOT_CODE);
      prev          = col_active[i];
    end
  end

  for (genvar i = 0; i < WORD_COLUMNS; i++) begin : g_lane
    bts_lane #(
      .TEXT_POSITIONS(TEXT_POSITIONS),
      .COLUMN        (i)
    ) u_lane (
      .text_codes(text_r),
      .col_code  (col_code[i]),
      .col_active(col_active[i]),
      .hits      (lane_hits[i])
    );
  end

  always_comb begin
    read_code = BLANK_CODE;
    if ({1'b0, in_item.position} < 7'(TEXT_POSITIONS)) begin
      read_code = text_r[in_item.position[POS_W-1:0]];
    end
    ctrl          = '0;
    ctrl.valid    = accept;
    ctrl.find     = accept && (in_item.func == FUNC_FIND);
    ctrl.word_ok  = col_active[0];
    if (accept && in_item.func == FUNC_READ) ctrl.char_out = code_to_ascii(read_code);
  end

  always_comb begin
    text_nxt = text_r;
    fill_nxt = fill_r;
    if (accept) begin
      unique case (in_item.func)
        FUNC_CLEAR: begin
          for (int p = 0; p < TEXT_POSITIONS; p++) text_nxt[p] = BLANK_CODE;
          fill_nxt = '0;
        end
        FUNC_APPEND: begin
          if (fill_r < FILL_W'(TEXT_POSITIONS)) begin
            text_nxt[fill_r[POS_W-1:0]] = ascii_to_code(in_item.char_in);
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        FUNC_FIND, FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < TEXT_POSITIONS; p++) text_r[p] <= BLANK_CODE;
      fill_r <= '0;
    end else begin
      text_r <= text_nxt;
      fill_r <= fill_nxt;
    end
  end

  bts_merge #(
    .TEXT_POSITIONS(TEXT_POSITIONS),
    .WORD_COLUMNS  (WORD_COLUMNS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .lane_hits(lane_hits),
    .ctrl     (ctrl),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TEXT_POSITIONS))
    else $error("fill position beyond page");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.func == FUNC_CLEAR) |=> (fill_r == '0))
    else $error("clear left a fill position");

  a_append_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.func == FUNC_APPEND) && (fill_r < FILL_W'(TEXT_POSITIONS))
      |=> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("append did not advance fill position");

endmodule
